/* src/mcr_pkg.sv */
// Shared types, widths and helpers for the midpoint circle rasterizer.
package mcr_pkg;

  // Coordinate and color widths of the point stream.
  localparam int COORD_BITS  = 16;
  localparam int COLOR_BITS  = 32;
  localparam int RADIUS_BITS = 16;

  // Octant walker widths: signed point and signed decision error.
  localparam int X_BITS   = 18;
  localparam int ERR_BITS = 20;

  // Points per step and the queue between front and back.
  localparam int POINTS_PER_STEP = 8;
  localparam int SLOT_BITS       = $clog2(POINTS_PER_STEP);
  localparam int QUEUE_DEPTH     = 2;
  localparam int QPTR_BITS       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS       = $clog2(QUEUE_DEPTH + 1);

  // Command codes.
  typedef enum logic {
    CMD_START = 1'b0,
    CMD_STEP  = 1'b1
  } cmd_t;

  // Input item.
  typedef struct packed {
    cmd_t                   cmd;
    logic [COORD_BITS-1:0]  center_x;
    logic [COORD_BITS-1:0]  center_y;
    logic [RADIUS_BITS-1:0] radius;
    logic [COLOR_BITS-1:0]  pixel_color;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic [COORD_BITS-1:0] point_x;
    logic [COORD_BITS-1:0] point_y;
    logic [COLOR_BITS-1:0] point_color;
    logic                  last_of_step;
    logic                  circle_done;
  } out_item_t;

  // One step handed from the front to the back.
  typedef struct packed {
    logic [COORD_BITS-1:0] cx;
    logic [COORD_BITS-1:0] cy;
    logic [COORD_BITS-1:0] ox;
    logic [COORD_BITS-1:0] oy;
    logic [COLOR_BITS-1:0] color;
    logic                  done;
  } step_job_t;

  // How one mirrored point is formed from the octant offsets.
  typedef struct packed {
    logic swap;   // x takes oy and y takes ox
    logic neg_x;  // subtract the x offset from the center
    logic neg_y;  // subtract the y offset from the center
  } mirror_t;

  // Mirror pattern for each slot of a step, in emission order.
  function automatic mirror_t mirror_of(input logic [SLOT_BITS-1:0] slot);
    mirror_t m;
    case (slot)
      3'd0:    m = '{swap: 1'b0, neg_x: 1'b0, neg_y: 1'b0};
      3'd1:    m = '{swap: 1'b1, neg_x: 1'b0, neg_y: 1'b0};
      3'd2:    m = '{swap: 1'b1, neg_x: 1'b1, neg_y: 1'b0};
      3'd3:    m = '{swap: 1'b0, neg_x: 1'b1, neg_y: 1'b0};
      3'd4:    m = '{swap: 1'b0, neg_x: 1'b1, neg_y: 1'b1};
      3'd5:    m = '{swap: 1'b1, neg_x: 1'b1, neg_y: 1'b1};
      3'd6:    m = '{swap: 1'b1, neg_x: 1'b0, neg_y: 1'b1};
      3'd7:    m = '{swap: 1'b0, neg_x: 1'b0, neg_y: 1'b1};
      default: m = '{swap: 1'b0, neg_x: 1'b0, neg_y: 1'b0};
    endcase
    return m;
  endfunction

endpackage

/* src/mcr_front.sv */
// Front end: accepts commands, walks the octant and queues one job per step.
module mcr_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mcr_pkg::in_item_t   in_data,
  input  logic                q_full,
  output logic                q_push,
  output mcr_pkg::step_job_t  q_job
);

  // Circle state.
  logic                                 active_r, active_nxt;
  logic [mcr_pkg::COORD_BITS-1:0]       cx_r, cx_nxt;
  logic [mcr_pkg::COORD_BITS-1:0]       cy_r, cy_nxt;
  logic [mcr_pkg::COLOR_BITS-1:0]       color_r, color_nxt;
  logic signed [mcr_pkg::X_BITS-1:0]    x_r, x_nxt;
  logic signed [mcr_pkg::X_BITS-1:0]    y_r, y_nxt;
  logic signed [mcr_pkg::ERR_BITS-1:0]  err_r, err_nxt;

  // Working values of the error update.
  logic                                 accept, is_start;
  logic signed [mcr_pkg::X_BITS-1:0]    base_x, base_y, x1, y1;
  logic signed [mcr_pkg::ERR_BITS-1:0]  base_e, e1, e2, y1_ext, x1_ext;
  logic                                 step_y, step_x, done;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign is_start = (in_data.cmd == mcr_pkg::CMD_START);

  // A start restarts the walk from (radius, 0) with zero error.
  always_comb begin
    if (is_start) begin
      base_x = mcr_pkg::X_BITS'(in_data.radius);
      base_y = '0;
      base_e = '0;
    end else begin
      base_x = x_r;
      base_y = y_r;
      base_e = err_r;
    end
  end

  // Midpoint error update: maybe advance y, then maybe retreat x.
  always_comb begin
    step_y = base_e[mcr_pkg::ERR_BITS-1] || (base_e == '0);
    y1     = step_y ? (base_y + mcr_pkg::X_BITS'(1)) : base_y;
    y1_ext = mcr_pkg::ERR_BITS'(y1);
    e1     = step_y ? (base_e + {y1_ext[mcr_pkg::ERR_BITS-2:0], 1'b1}) : base_e;
    step_x = !e1[mcr_pkg::ERR_BITS-1] && (e1 != '0);
    x1     = step_x ? (base_x - mcr_pkg::X_BITS'(1)) : base_x;
    x1_ext = mcr_pkg::ERR_BITS'(x1);
    e2     = step_x ? (e1 - {x1_ext[mcr_pkg::ERR_BITS-2:0], 1'b1}) : e1;
    done   = (x1 < y1);
  end

  // A step on an idle walker is taken and dropped.
  assign q_push = accept && (is_start || active_r);

  // The job carries the offsets before the update.
  always_comb begin
    q_job.cx    = is_start ? in_data.center_x : cx_r;
    q_job.cy    = is_start ? in_data.center_y : cy_r;
    q_job.color = is_start ? in_data.pixel_color : color_r;
    q_job.ox    = base_x[mcr_pkg::COORD_BITS-1:0];
    q_job.oy    = base_y[mcr_pkg::COORD_BITS-1:0];
    q_job.done  = done;
  end

  // Next state of the walker.
  always_comb begin
    active_nxt = active_r;
    cx_nxt     = cx_r;
    cy_nxt     = cy_r;
    color_nxt  = color_r;
    x_nxt      = x_r;
    y_nxt      = y_r;
    err_nxt    = err_r;
    if (q_push) begin
      active_nxt = !done;
      cx_nxt     = q_job.cx;
      cy_nxt     = q_job.cy;
      color_nxt  = q_job.color;
      x_nxt      = x1;
      y_nxt      = y1;
      err_nxt    = e2;
    end
  end

  // Only the active flag needs a reset value.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cx_r    <= cx_nxt;
    cy_r    <= cy_nxt;
    color_r <= color_nxt;
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    err_r   <= err_nxt;
  end

endmodule

/* src/mcr_queue.sv */
// Short job queue between the front end and the point emitter.
module mcr_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  mcr_pkg::step_job_t  push_job,
  output logic                full,
  input  logic                pop,
  output logic                empty,
  output mcr_pkg::step_job_t  head_job
);

  mcr_pkg::step_job_t                   slot_r [mcr_pkg::QUEUE_DEPTH];
  logic [mcr_pkg::QPTR_BITS-1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [mcr_pkg::QPTR_BITS-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [mcr_pkg::QCNT_BITS-1:0]        count_r, count_nxt;
  logic                                 do_push, do_pop;

  assign full     = (count_r == mcr_pkg::QCNT_BITS'(mcr_pkg::QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_job = slot_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == mcr_pkg::QPTR_BITS'(mcr_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + mcr_pkg::QPTR_BITS'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == mcr_pkg::QPTR_BITS'(mcr_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + mcr_pkg::QPTR_BITS'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + mcr_pkg::QCNT_BITS'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - mcr_pkg::QCNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Job storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

/* src/mcr_back.sv */
// Back end: emits eight mirrored points per step, one per cycle unless stalled.
module mcr_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  mcr_pkg::step_job_t  q_head,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output mcr_pkg::out_item_t  out_data
);

  mcr_pkg::step_job_t                   job_r, job_nxt;
  logic                                 busy_r, busy_nxt;
  logic [mcr_pkg::SLOT_BITS-1:0]        slot_r, slot_nxt;
  logic                                 ovalid_r, ovalid_nxt;
  mcr_pkg::out_item_t                   odata_r, odata_nxt;

  logic                                 advance, last_slot;
  mcr_pkg::mirror_t                     mir;
  logic [mcr_pkg::COORD_BITS-1:0]       off_x, off_y, px, py;

  // The output register can take a point when empty or being drained.
  assign advance   = busy_r && (!ovalid_r || out_ready);
  assign last_slot = (slot_r == mcr_pkg::SLOT_BITS'(mcr_pkg::POINTS_PER_STEP - 1));
  assign q_pop     = !q_empty && (!busy_r || (advance && last_slot));

  // Mirror the octant offsets for the current slot.
  always_comb begin
    mir   = mcr_pkg::mirror_of(slot_r);
    off_x = mir.swap ? job_r.oy : job_r.ox;
    off_y = mir.swap ? job_r.ox : job_r.oy;
    px    = mir.neg_x ? (job_r.cx - off_x) : (job_r.cx + off_x);
    py    = mir.neg_y ? (job_r.cy - off_y) : (job_r.cy + off_y);
  end

  // Slot sequencer and job register.
  always_comb begin
    job_nxt  = job_r;
    busy_nxt = busy_r;
    slot_nxt = slot_r;
    if (advance) begin
      slot_nxt = slot_r + mcr_pkg::SLOT_BITS'(1);
      if (last_slot) begin
        busy_nxt = 1'b0;
      end
    end
    if (q_pop) begin
      job_nxt  = q_head;
      busy_nxt = 1'b1;
      slot_nxt = '0;
    end
  end

  // Output register.
  always_comb begin
    ovalid_nxt = ovalid_r;
    odata_nxt  = odata_r;
    if (out_ready) begin
      ovalid_nxt = 1'b0;
    end
    if (advance) begin
      ovalid_nxt             = 1'b1;
      odata_nxt.point_x      = px;
      odata_nxt.point_y      = py;
      odata_nxt.point_color  = job_r.color;
      odata_nxt.last_of_step = last_slot;
      odata_nxt.circle_done  = last_slot && job_r.done;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      slot_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      slot_r   <= slot_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r   <= job_nxt;
    odata_r <= odata_nxt;
  end

  assign out_valid = ovalid_r;
  assign out_data  = odata_r;

endmodule

/* src/midpoint_circle_rasterizer_unit.sv */
// Top level of the midpoint circle rasterizer: front end, job queue, point emitter.
//
//   Channel | Direction | Handshake            | Beat
//   in_     | input     | in_valid / in_ready   | one command (start or step)
//   out_    | output    | out_valid / out_ready | one plotted point
//
// Each accepted command that yields a step produces eight point beats, one per
// cycle while out_ready stays high, from the point emitter's single output
// register. The front end computes the next octant point in the accept cycle
// and takes a new command whenever the two-entry job queue has room, so it
// runs ahead while points drain. A command's first point passes through the
// queue, the emitter's job register and its output register.
// A synchronous active-low reset empties the queue and idles the walker.
// A stall on out_ready holds the current point; the queue then fills and
// in_ready drops.
module midpoint_circle_rasterizer_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mcr_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mcr_pkg::out_item_t  out_data
);

  logic                q_full, q_empty, q_push, q_pop;
  mcr_pkg::step_job_t  push_job, head_job;

  // Command intake and octant walker.
  mcr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (push_job)
  );

  // Job queue.
  mcr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head_job (head_job)
  );

  // Point emitter.
  mcr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (head_job),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* src/mcr_checker.sv */
// Port-level assertions for the midpoint circle rasterizer, bound to the top level.
module mcr_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input mcr_pkg::in_item_t   in_data,
  input logic                out_valid,
  input logic                out_ready,
  input mcr_pkg::out_item_t  out_data
);

  // A waiting command beat stays offered and unchanged.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("command beat changed while waiting");

  // A stalled point beat stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("point beat changed while stalled");

  // The end of a circle only comes on the last point of a step.
  a_done_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.circle_done |-> out_data.last_of_step)
    else $error("circle_done without last_of_step");

  // The beat after a step's last point opens a new step.
  a_step_restart: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_data.last_of_step
    |=> !(out_valid && out_data.last_of_step))
    else $error("step closed twice in a row");

  // Reset leaves no point on offer.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("point offered right after reset");

endmodule

bind midpoint_circle_rasterizer_unit mcr_checker u_mcr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

/* test/mcr_point_checker.sv */
// Point stream checker for the midpoint circle rasterizer: octant walker and compare.
module mcr_point_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  mcr_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  mcr_pkg::out_item_t out_data,
  output int                 mismatch_count,
  output int                 points_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_REPORTS = 10;

  // Shadow of the walker: latched circle and the current octant point.
  logic                           walker_active;
  logic [mcr_pkg::COORD_BITS-1:0] held_cx;
  logic [mcr_pkg::COORD_BITS-1:0] held_cy;
  logic [mcr_pkg::COLOR_BITS-1:0] held_color;
  int                             oct_x;
  int                             oct_y;
  int                             dec_err;

  mcr_pkg::out_item_t expected_points[$];
  int                 bad_points;

  // Emit the eight mirrored points of the current octant point, then advance it.
  task automatic walk_octant_step();
    logic [mcr_pkg::COORD_BITS-1:0] ox;
    logic [mcr_pkg::COORD_BITS-1:0] oy;
    logic [mcr_pkg::COORD_BITS-1:0] xs [8];
    logic [mcr_pkg::COORD_BITS-1:0] ys [8];
    logic                           finished;
    mcr_pkg::out_item_t             pt;
    ox = oct_x[mcr_pkg::COORD_BITS-1:0];
    oy = oct_y[mcr_pkg::COORD_BITS-1:0];
    if (dec_err <= 0) begin
      oct_y   = oct_y + 1;
      dec_err = dec_err + 2 * oct_y + 1;
    end
    if (dec_err > 0) begin
      oct_x   = oct_x - 1;
      dec_err = dec_err - (2 * oct_x + 1);
    end
    finished = (oct_x < oct_y);
    xs = '{held_cx + ox, held_cx + oy, held_cx - oy, held_cx - ox,
           held_cx - ox, held_cx - oy, held_cx + oy, held_cx + ox};
    ys = '{held_cy + oy, held_cy + ox, held_cy + ox, held_cy + oy,
           held_cy - oy, held_cy - ox, held_cy - ox, held_cy - oy};
    for (int k = 0; k < mcr_pkg::POINTS_PER_STEP; k++) begin
      pt.point_x      = xs[k];
      pt.point_y      = ys[k];
      pt.point_color  = held_color;
      pt.last_of_step = (k == mcr_pkg::POINTS_PER_STEP - 1);
      pt.circle_done  = (k == mcr_pkg::POINTS_PER_STEP - 1) && finished;
      expected_points.push_back(pt);
    end
    if (finished) begin
      walker_active = 1'b0;
    end
  endtask

  // Predict on command beats, compare on point beats.
  always @(posedge clk) begin
    mcr_pkg::out_item_t want;
    if (!rst_n) begin
      walker_active = 1'b0;
      held_cx       = '0;
      held_cy       = '0;
      held_color    = '0;
      oct_x         = 0;
      oct_y         = 0;
      dec_err       = 0;
      expected_points.delete();
    end else begin
      if (in_valid && in_ready) begin
        if (in_data.cmd == mcr_pkg::CMD_START) begin
          held_cx       = in_data.center_x;
          held_cy       = in_data.center_y;
          held_color    = in_data.pixel_color;
          oct_x         = int'(in_data.radius);
          oct_y         = 0;
          dec_err       = 0;
          walker_active = 1'b1;
          walk_octant_step();
        end else if (walker_active) begin
          walk_octant_step();
        end
      end
      if (out_valid && out_ready) begin
        if (expected_points.size() == 0) begin
          bad_points++;
          if (bad_points <= MAX_REPORTS) begin
            $display("%0t: unexpected point beat x=%h y=%h color=%h last=%b done=%b",
                     $realtime, out_data.point_x, out_data.point_y,
                     out_data.point_color, out_data.last_of_step, out_data.circle_done);
          end
        end else begin
          want = expected_points.pop_front();
          if (want.point_x !== out_data.point_x || want.point_y !== out_data.point_y ||
              want.point_color !== out_data.point_color ||
              want.last_of_step !== out_data.last_of_step ||
              want.circle_done !== out_data.circle_done) begin
            bad_points++;
            if (bad_points <= MAX_REPORTS) begin
              $display("%0t: point mismatch", $realtime);
              $display("  expected x=%h y=%h color=%h last=%b done=%b",
                       want.point_x, want.point_y, want.point_color,
                       want.last_of_step, want.circle_done);
              $display("  actual   x=%h y=%h color=%h last=%b done=%b",
                       out_data.point_x, out_data.point_y, out_data.point_color,
                       out_data.last_of_step, out_data.circle_done);
            end
          end
        end
      end
    end
    mismatch_count <= bad_points;
    points_pending <= expected_points.size();
  end

endmodule

/* test/tb_top.sv */
// Top of the rasterizer testbench: clock, reset, command and ready drivers, verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RESET_CYCLES    = 6;
  localparam int ITEM_TARGET     = 125;
  localparam int CALM_ITEMS_FROM = 60;
  localparam int CALM_ITEMS_TO   = 95;
  localparam int HOLD_FROM       = 400;
  localparam int HOLD_LEN        = 180;
  localparam int CALM_FROM       = 1000;
  localparam int CALM_LEN        = 300;
  localparam int IDLE_PERCENT    = 35;
  localparam int STALL_LIMIT     = 3000;
  localparam int DRAIN_CYCLES    = 24;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  mcr_pkg::in_item_t  in_data   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  mcr_pkg::out_item_t out_data;

  int mismatch_count;
  int points_pending;
  int items_sent   = 0;
  int quiet_cycles = 0;
  bit sender_calm  = 1'b0;

  always #2 clk = ~clk;

  midpoint_circle_rasterizer_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  mcr_point_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .mismatch_count (mismatch_count),
    .points_pending (points_pending)
  );

  // Centers lean toward the ends of the range so the mirrored points wrap.
  function automatic logic [mcr_pkg::COORD_BITS-1:0] pick_coord();
    logic [mcr_pkg::COORD_BITS-1:0] c;
    case ($urandom_range(0, 3))
      0:       c = mcr_pkg::COORD_BITS'($urandom_range(0, 15));
      1:       c = '1 - mcr_pkg::COORD_BITS'($urandom_range(0, 15));
      default: c = mcr_pkg::COORD_BITS'($urandom);
    endcase
    return c;
  endfunction

  function automatic mcr_pkg::in_item_t start_cmd(logic [mcr_pkg::COORD_BITS-1:0] cx,
                                                  logic [mcr_pkg::COORD_BITS-1:0] cy,
                                                  logic [mcr_pkg::RADIUS_BITS-1:0] r,
                                                  logic [mcr_pkg::COLOR_BITS-1:0] color);
    mcr_pkg::in_item_t item;
    item.cmd         = mcr_pkg::CMD_START;
    item.center_x    = cx;
    item.center_y    = cy;
    item.radius      = r;
    item.pixel_color = color;
    return item;
  endfunction

  // Step commands carry junk in the fields that the block ignores.
  function automatic mcr_pkg::in_item_t step_cmd();
    mcr_pkg::in_item_t item;
    item.cmd         = mcr_pkg::CMD_STEP;
    item.center_x    = mcr_pkg::COORD_BITS'($urandom);
    item.center_y    = mcr_pkg::COORD_BITS'($urandom);
    item.radius      = mcr_pkg::RADIUS_BITS'($urandom);
    item.pixel_color = mcr_pkg::COLOR_BITS'($urandom);
    return item;
  endfunction

  // Offer one command beat after a random idle gap and wait until it is taken.
  task automatic send_cmd(input mcr_pkg::in_item_t item);
    while (!sender_calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic send_steps(input int n);
    repeat (n) send_cmd(step_cmd());
  endtask

  // Command stream: directed corner cases, then random circles.
  initial begin
    mcr_pkg::in_item_t all_ones;
    int                kind;
    int                r;
    all_ones = '1;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // Step while idle, zero radius at both ends of the range, radius one.
    send_cmd(all_ones);
    send_cmd(start_cmd('0, '0, '0, '0));
    send_cmd(step_cmd());
    send_cmd(start_cmd('1, '1, '0, '1));
    send_cmd(start_cmd('0, '0, 16'd1, 32'hA5A5_5A5A));
    // Small circle run to its end, then two steps past it.
    send_cmd(start_cmd(16'h8000, 16'h7FFF, 16'd5, 32'h0000_0001));
    send_steps(5);
    // Largest radius, dropped by a new start while still running.
    send_cmd(start_cmd('1, '0, '1, '1));
    send_steps(3);
    send_cmd(start_cmd(16'h1234, 16'hFEDC, 16'd100, 32'h8000_0000));
    send_steps(2);
    send_cmd(start_cmd('0, '1, '1, 32'h7FFF_FFFF));
    send_steps(1);
    send_cmd(start_cmd(16'd10, 16'd10, 16'd2, 32'h0F0F_0F0F));
    send_steps(3);

    while (items_sent < ITEM_TARGET) begin
      sender_calm = (items_sent >= CALM_ITEMS_FROM) && (items_sent < CALM_ITEMS_TO);
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        // Whole small circle, sometimes cut short, sometimes overrun.
        r = $urandom_range(0, 24);
        send_cmd(start_cmd(pick_coord(), pick_coord(), mcr_pkg::RADIUS_BITS'(r),
                           mcr_pkg::COLOR_BITS'($urandom)));
        send_steps((r * 3) / 4 + $urandom_range(0, 2));
      end else if (kind < 70) begin
        // Full-range radius, a few steps, then abandoned.
        send_cmd(start_cmd(pick_coord(), pick_coord(), mcr_pkg::RADIUS_BITS'($urandom),
                           mcr_pkg::COLOR_BITS'($urandom)));
        send_steps($urandom_range(1, 4));
      end else if (kind < 85) begin
        // Restart straight away.
        send_cmd(start_cmd(pick_coord(), pick_coord(),
                           mcr_pkg::RADIUS_BITS'($urandom_range(0, 40)),
                           mcr_pkg::COLOR_BITS'($urandom)));
        send_cmd(start_cmd(pick_coord(), pick_coord(),
                           mcr_pkg::RADIUS_BITS'($urandom_range(0, 40)),
                           mcr_pkg::COLOR_BITS'($urandom)));
        send_steps($urandom_range(1, 3));
      end else begin
        send_steps($urandom_range(1, 3));
      end
    end
    sender_calm = 1'b0;

    // Drain and give the verdict.
    @(negedge clk);
    in_valid <= 1'b0;
    while (points_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && points_pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Point receiver: random stalls, one long hold-off, one stretch always ready.
  initial begin
    int rx_cycle;
    rx_cycle = 0;
    forever begin
      @(negedge clk);
      rx_cycle++;
      if (rx_cycle >= HOLD_FROM && rx_cycle < HOLD_FROM + HOLD_LEN) begin
        out_ready <= 1'b0;
      end else if (rx_cycle >= CALM_FROM && rx_cycle < CALM_FROM + CALM_LEN) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
    end
  end

  // Watchdog on cycles without any beat on either channel.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

endmodule

/* files.f */
src/mcr_pkg.sv
src/mcr_front.sv
src/mcr_queue.sv
src/mcr_back.sv
src/midpoint_circle_rasterizer_unit.sv
src/mcr_checker.sv
test/mcr_point_checker.sv
test/tb_top.sv
